// ===== rtl/jsmd_pkg.sv =====
// Shared types and constants for the job-shop makespan decoder.
// No dependencies; jsmd_route_mem and the top level refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package jsmd_pkg;

    // Default sizing handed to the top level
    localparam int DEF_JOBS          = 16;
    localparam int DEF_MACHINES      = 16;
    localparam int DEF_STEPS_PER_JOB = 16;
    localparam int DEF_TIME_BITS     = 16;

    // Fixed widths of the stream fields
    localparam int JOB_W      = 4;
    localparam int STEP_W     = 4;
    localparam int MACH_W     = 4;
    localparam int DUR_W      = 8;
    localparam int SPAN_W     = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    // Kind of input word, carried in s_tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_GENE = 1'b1
    } op_t;

    // One routing table entry
    typedef struct packed {
        logic [MACH_W-1:0] machine;
        logic [DUR_W-1:0]  duration;
    } route_entry_t;

endpackage

`default_nettype wire

// ===== rtl/jsmd_route_mem.sv =====
// Routing table: machine and duration for each (job, step), one write and one read port.
// Depends on jsmd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module jsmd_route_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire jsmd_pkg::route_entry_t wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output jsmd_pkg::route_entry_t      rdata
);

    jsmd_pkg::route_entry_t mem [DEPTH];
    jsmd_pkg::route_entry_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/jsmd_ready_mem.sv =====
// Ready-time memory with per-entry valid flags; an entry not valid reads as zero.
// A clear drops all valid flags at once. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module jsmd_ready_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [W-1:0]       rdata
);

    logic [W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     data_reg;
    logic             hit_reg;

    // data array
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // valid flags, clear wins over a write in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // registered read; a read that meets a clear sees an empty entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (re) begin
            hit_reg <= valid_reg[raddr] && !clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            data_reg <= mem[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/job_shop_makespan_decoder_top.sv =====
// Top level of the job-shop makespan decoder: stream ports, step counters, three-stage
// gene pipeline. Depends on jsmd_pkg, jsmd_route_mem and jsmd_ready_mem.
//
//  channel | dir | tdata (low bit up)                            | tuser          | tlast
//  s_      | in  | job[3:0] step_index[7:4] machine[11:8]        | operation[0]   | last_gene
//          |     | duration[19:12], zero pad [23:20]             |                |
//  m_      | out | makespan[15:0]                                | error[0]       | -
//
// One word per cycle while s_tready is high. A gene passes three stages: step count and
// routing read, then job and machine ready-time reads, then max/add and write back; the
// result of a last gene goes to the output register. Loads are done in the cycle they are accepted.
// Reset is synchronous; per-chromosome state uses valid flags, so no clearing pass is run.
// s_tready drops only while a finished last gene cannot enter a still-occupied output register.
`timescale 1ns / 1ps
`default_nettype none

module job_shop_makespan_decoder_top #(
    parameter int JOBS          = jsmd_pkg::DEF_JOBS,
    parameter int MACHINES      = jsmd_pkg::DEF_MACHINES,
    parameter int STEPS_PER_JOB = jsmd_pkg::DEF_STEPS_PER_JOB,
    parameter int TIME_BITS     = jsmd_pkg::DEF_TIME_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // job[3:0], step_index[7:4], machine[11:8], duration[19:12], zero[23:20]
    input  wire logic [jsmd_pkg::S_DATA_W-1:0] s_tdata,
    // operation[0]
    input  wire logic [0:0]                    s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // makespan[15:0]
    output logic [jsmd_pkg::M_DATA_W-1:0]      m_tdata,
    // error[0]
    output logic [0:0]                         m_tuser
);

    localparam int JW     = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int MW     = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int SCW    = $clog2(STEPS_PER_JOB + 1);
    localparam int RDEPTH = JOBS * STEPS_PER_JOB;
    localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int TB     = TIME_BITS;

    // ---------------- input field unpacking ----------------
    jsmd_pkg::op_t                s_op;
    logic [jsmd_pkg::JOB_W-1:0]  s_job;
    logic [jsmd_pkg::STEP_W-1:0] s_step;
    logic [jsmd_pkg::MACH_W-1:0] s_mach;
    logic [jsmd_pkg::DUR_W-1:0]  s_dur;

    assign s_op   = jsmd_pkg::op_t'(s_tuser[0]);
    assign s_job  = s_tdata[3:0];
    assign s_step = s_tdata[7:4];
    assign s_mach = s_tdata[11:8];
    assign s_dur  = s_tdata[19:12];

    logic accept, advance, stall;
    logic acc_gene, acc_load;

    assign accept   = s_tvalid && s_tready;
    assign acc_gene = accept && (s_op == jsmd_pkg::OP_GENE);
    assign acc_load = accept && (s_op == jsmd_pkg::OP_LOAD);

    // ---------------- stage A: step counters and routing access ----------------
    logic [SCW-1:0] cnt_reg [JOBS];
    logic [JW+3:0]  job_ext;
    logic [JW-1:0]  a_jidx;
    logic [SCW-1:0] a_cnt;
    logic           a_job_in, a_step_ok, a_apply, a_load_ok;
    logic [31:0]    a_slot_w;
    logic [RAW-1:0] a_slot;
    logic [SCW+3:0] a_sel_step;

    assign job_ext   = (JW + 4)'(s_job);
    assign a_jidx    = job_ext[JW-1:0];
    assign a_cnt     = cnt_reg[a_jidx];
    assign a_job_in  = 32'(s_job) < 32'(JOBS);
    assign a_step_ok = 32'(a_cnt) < 32'(STEPS_PER_JOB);
    assign a_apply   = a_job_in && a_step_ok;
    assign a_load_ok = a_job_in && (32'(s_step) < 32'(STEPS_PER_JOB))
                       && (32'(s_mach) < 32'(MACHINES));

    // slot = job * STEPS_PER_JOB + step, step from the counter on genes
    assign a_sel_step = (s_op == jsmd_pkg::OP_GENE) ? (SCW + 4)'(a_cnt) : (SCW + 4)'(s_step);
    assign a_slot_w   = 32'(a_jidx) * 32'(STEPS_PER_JOB) + 32'(a_sel_step);
    assign a_slot     = a_slot_w[RAW-1:0];

    // counters advance on an applied gene; a last gene starts a fresh chromosome
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < JOBS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (acc_gene) begin
            if (s_tlast) begin
                for (int i = 0; i < JOBS; i++) begin
                    cnt_reg[i] <= '0;
                end
            end else if (a_apply) begin
                cnt_reg[a_jidx] <= a_cnt + SCW'(1);
            end
        end
    end

    jsmd_pkg::route_entry_t route_wdata, route_rdata;

    assign route_wdata.machine  = s_mach;
    assign route_wdata.duration = s_dur;

    jsmd_route_mem #(
        .DEPTH (RDEPTH),
        .AW    (RAW)
    ) u_route (
        .aclk  (aclk),
        .we    (acc_load && a_load_ok),
        .waddr (a_slot),
        .wdata (route_wdata),
        .re    (acc_gene && a_apply),
        .raddr (a_slot),
        .rdata (route_rdata)
    );

    // ---------------- stage B: ready-time reads ----------------
    logic          b_valid_reg, b_apply_reg, b_last_reg, b_err_reg;
    logic [JW-1:0] b_job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= acc_gene;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_apply_reg <= a_apply;
            b_last_reg  <= s_tlast;
            b_err_reg   <= !a_apply;
            b_job_reg   <= a_jidx;
        end
    end

    logic [MW+3:0] mach_ext;
    logic [MW-1:0] b_mach;
    logic          b_read;

    // out-of-range machine falls back to machine zero
    assign mach_ext = (MW + 4)'(route_rdata.machine);
    assign b_mach   = (32'(route_rdata.machine) < 32'(MACHINES)) ? mach_ext[MW-1:0] : '0;
    assign b_read   = advance && b_valid_reg && b_apply_reg;

    // ---------------- stage C: max, add, write back ----------------
    logic                     c_valid_reg, c_apply_reg, c_last_reg, c_err_reg;
    logic [JW-1:0]            c_job_reg;
    logic [MW-1:0]            c_mach_reg;
    logic [jsmd_pkg::DUR_W-1:0] c_dur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (advance) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            c_apply_reg <= b_apply_reg;
            c_last_reg  <= b_last_reg;
            c_err_reg   <= b_err_reg;
            c_job_reg   <= b_job_reg;
            c_mach_reg  <= b_mach;
            c_dur_reg   <= route_rdata.duration;
        end
    end

    logic [TB-1:0] job_rd, mach_rd;
    logic          c_clear, c_write;

    assign c_clear = advance && c_valid_reg && c_last_reg;
    assign c_write = advance && c_valid_reg && c_apply_reg && !c_last_reg;

    // forwarding record of the write made at the edge the stage-C reads were taken
    logic          fw_valid_reg;
    logic [JW-1:0] fw_job_reg;
    logic [MW-1:0] fw_mach_reg;
    logic [TB-1:0] fw_time_reg;

    logic [TB-1:0] c_finish;

    jsmd_ready_mem #(
        .DEPTH (JOBS),
        .AW    (JW),
        .W     (TB)
    ) u_job_ready (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (c_clear),
        .we      (c_write),
        .waddr   (c_job_reg),
        .wdata   (c_finish),
        .re      (b_read),
        .raddr   (b_job_reg),
        .rdata   (job_rd)
    );

    jsmd_ready_mem #(
        .DEPTH (MACHINES),
        .AW    (MW),
        .W     (TB)
    ) u_mach_ready (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (c_clear),
        .we      (c_write),
        .waddr   (c_mach_reg),
        .wdata   (c_finish),
        .re      (b_read),
        .raddr   (b_mach),
        .rdata   (mach_rd)
    );

    logic [TB-1:0] c_jr, c_mr, c_start;
    logic [TB:0]   c_sum;
    logic          c_sat;

    // ready times with forwarding, then start = max, finish = start + duration (saturating)
    assign c_jr     = (fw_valid_reg && fw_job_reg == c_job_reg) ? fw_time_reg : job_rd;
    assign c_mr     = (fw_valid_reg && fw_mach_reg == c_mach_reg) ? fw_time_reg : mach_rd;
    assign c_start  = (c_mr > c_jr) ? c_mr : c_jr;
    assign c_sum    = {1'b0, c_start} + (TB + 1)'(c_dur_reg);
    assign c_sat    = c_sum[TB];
    assign c_finish = c_sat ? '1 : c_sum[TB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_valid_reg <= 1'b0;
        end else if (advance) begin
            fw_valid_reg <= c_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fw_job_reg  <= c_job_reg;
            fw_mach_reg <= c_mach_reg;
            fw_time_reg <= c_finish;
        end
    end

    // running makespan and error flag
    logic [TB-1:0] makespan_reg, span_next;
    logic          error_reg, err_next;

    assign span_next = (c_apply_reg && c_finish > makespan_reg) ? c_finish : makespan_reg;
    assign err_next  = error_reg || c_err_reg || (c_apply_reg && c_sat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            makespan_reg <= '0;
            error_reg    <= 1'b0;
        end else if (advance && c_valid_reg) begin
            if (c_last_reg) begin
                makespan_reg <= '0;
                error_reg    <= 1'b0;
            end else begin
                makespan_reg <= span_next;
                error_reg    <= err_next;
            end
        end
    end

    // clamp to the 16-bit output field
    logic [TB+15:0]                  span_ext;
    logic                            span_hi;
    logic [jsmd_pkg::SPAN_W-1:0]     out_span;

    assign span_ext = (TB + 16)'(span_next);
    assign span_hi  = span_ext[TB+15:16] != '0;
    assign out_span = span_hi ? '1 : span_ext[15:0];

    // ---------------- output register ----------------
    logic                        m_valid_reg;
    logic [jsmd_pkg::SPAN_W-1:0] m_span_reg;
    logic                        m_err_reg;

    assign stall    = c_valid_reg && c_last_reg && m_valid_reg && !m_tready;
    assign advance  = !stall;
    assign s_tready = !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_clear) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_clear) begin
            m_span_reg <= out_span;
            m_err_reg  <= err_next || span_hi;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_span_reg;
    assign m_tuser[0] = m_err_reg;

    // ---------------- assertions ----------------
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(c_valid_reg && c_last_reg))
        else $error("result word without a last gene leaving stage C");

    a_fresh_chromosome: assert property (@(posedge aclk) disable iff (!aresetn)
        c_clear |=> (makespan_reg == '0 && !error_reg && !fw_valid_reg))
        else $error("chromosome state not cleared after last gene");

    a_ready_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && c_valid_reg && c_last_reg))
        else $error("input held off without a blocked result");

endmodule

`default_nettype wire
